// ===== rtl/nfcs_pkg.sv =====
package nfcs_pkg;

  localparam logic [1:0] OP_PROGRAM = 2'd0;
  localparam logic [1:0] OP_ERASE   = 2'd1;
  localparam logic [1:0] OP_STATUS  = 2'd2;
  localparam logic [1:0] OP_BLANK   = 2'd3;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam int MAX_RES = 7;
  localparam int CNT_W   = 3;

  localparam logic [15:0] CMD_UNLOCK1 = 16'h00AA;
  localparam logic [15:0] CMD_UNLOCK2 = 16'h0055;
  localparam logic [15:0] CMD_PROGRAM = 16'h00A0;
  localparam logic [15:0] CMD_ERASE   = 16'h0080;
  localparam logic [15:0] CMD_SECT_V0 = 16'h0050;
  localparam logic [15:0] CMD_SECT_V1 = 16'h0030;
  localparam logic [15:0] ERASED_WORD = 16'hFFFF;

  localparam logic [15:0] UNLOCK1_V0 = 16'h0555;
  localparam logic [15:0] UNLOCK2_V0 = 16'h02AA;
  localparam logic [15:0] UNLOCK1_V1 = 16'h5555;
  localparam logic [15:0] UNLOCK2_V1 = 16'h2AAA;

  localparam int TOGGLE_BIT = 6;

  localparam logic [1:0] REG_CHIP_VARIANT = 2'd0;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } nfcs_load_t;

endpackage

// ===== rtl/nfcs_in_if.sv =====
interface nfcs_in_if #(
  parameter int ADDR_BITS = 21
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [ADDR_BITS-1:0] address;
  logic [15:0]          data;

  modport source (output valid, output op, output address, output data, input ready);
  modport sink (input valid, input op, input address, input data, output ready);
endinterface

// ===== rtl/nfcs_out_if.sv =====
interface nfcs_out_if #(
  parameter int ADDR_BITS = 21
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [ADDR_BITS-1:0] bus_address;
  logic [15:0]          bus_data;
  logic                 success;
  logic                 last;

  modport source (output valid, output kind, output bus_address, output bus_data,
                  output success, output last, input ready);
  modport sink (input valid, input kind, input bus_address, input bus_data,
                input success, input last, output ready);
endinterface

// ===== rtl/nfcs_step.sv =====
module nfcs_step #(
  parameter int SECTOR_WORDS = 2048,
  parameter int ADDR_BITS    = 21
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_fire,
  input  logic [1:0]                                         in_op,
  input  logic [ADDR_BITS-1:0]                               in_address,
  input  logic [15:0]                                        in_data,
  input  logic                                               chip_variant,
  input  logic                                               buf_free,
  output logic                                               in_ready,
  output nfcs_pkg::nfcs_load_t                               load,
  output logic [nfcs_pkg::MAX_RES-1:0][ADDR_BITS+19:0]       res
);

  localparam int IDX_W = $clog2(SECTOR_WORDS + 1);
  localparam int SUM_W = (IDX_W > ADDR_BITS) ? IDX_W : ADDR_BITS;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POLL_FIRST,
    PH_POLL_LOOP,
    PH_CONF_A,
    PH_CONF_B,
    PH_BLANK
  } phase_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] addr;
    logic [15:0]          data;
    logic                 ok;
    logic                 last;
  } res_t;

  function automatic res_t mk(input logic [1:0] k, input logic [ADDR_BITS-1:0] a,
                              input logic [15:0] d, input logic ok, input logic lst);
    res_t r;
    r.kind = k;
    r.addr = a;
    r.data = d;
    r.ok   = ok;
    r.last = lst;
    return r;
  endfunction

  logic                 s1_valid_r;
  logic [1:0]           s1_op_r;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic [15:0]          s1_data_r;

  phase_t               phase_r, phase_nxt;
  logic                 is_erase_r, is_erase_nxt;
  logic                 old_toggle_r, old_toggle_nxt;
  logic                 confirm_toggle_r, confirm_toggle_nxt;
  logic [ADDR_BITS-1:0] sector_base_r, sector_base_nxt;
  logic [IDX_W-1:0]     blank_index_r, blank_index_nxt;

  logic                 adv;
  logic                 tbit;
  logic [ADDR_BITS-1:0] u1, u2, zero_addr;
  logic [15:0]          sect_code;
  logic [IDX_W-1:0]     idx_inc;
  logic [SUM_W-1:0]     blank_sum;
  res_t                 res_c [nfcs_pkg::MAX_RES];
  logic [nfcs_pkg::CNT_W-1:0] n_c;

  assign adv      = s1_valid_r && buf_free;
  assign in_ready = !s1_valid_r || adv;

  assign tbit      = s1_data_r[nfcs_pkg::TOGGLE_BIT];
  assign u1        = chip_variant ? ADDR_BITS'(nfcs_pkg::UNLOCK1_V1)
                                  : ADDR_BITS'(nfcs_pkg::UNLOCK1_V0);
  assign u2        = chip_variant ? ADDR_BITS'(nfcs_pkg::UNLOCK2_V1)
                                  : ADDR_BITS'(nfcs_pkg::UNLOCK2_V0);
  assign sect_code = chip_variant ? nfcs_pkg::CMD_SECT_V1 : nfcs_pkg::CMD_SECT_V0;
  assign zero_addr = '0;
  assign idx_inc   = blank_index_r + 1'b1;
  assign blank_sum = SUM_W'(sector_base_r) + SUM_W'(idx_inc);

  always_comb begin
    phase_nxt          = phase_r;
    is_erase_nxt       = is_erase_r;
    old_toggle_nxt     = old_toggle_r;
    confirm_toggle_nxt = confirm_toggle_r;
    sector_base_nxt    = sector_base_r;
    blank_index_nxt    = blank_index_r;
    n_c                = '0;
    for (int i = 0; i < nfcs_pkg::MAX_RES; i++) begin
      res_c[i] = '0;
    end
    unique case (s1_op_r)
      nfcs_pkg::OP_PROGRAM, nfcs_pkg::OP_ERASE: begin
        if (phase_r == PH_IDLE) begin
          res_c[0] = mk(nfcs_pkg::KIND_WRITE, u1, nfcs_pkg::CMD_UNLOCK1, 1'b0, 1'b0);
          res_c[1] = mk(nfcs_pkg::KIND_WRITE, u2, nfcs_pkg::CMD_UNLOCK2, 1'b0, 1'b0);
          phase_nxt = PH_POLL_FIRST;
          if (s1_op_r == nfcs_pkg::OP_PROGRAM) begin
            res_c[2] = mk(nfcs_pkg::KIND_WRITE, u1, nfcs_pkg::CMD_PROGRAM, 1'b0, 1'b0);
            res_c[3] = mk(nfcs_pkg::KIND_WRITE, s1_addr_r, s1_data_r, 1'b0, 1'b0);
            res_c[4] = mk(nfcs_pkg::KIND_READ, zero_addr, 16'd0, 1'b0, 1'b1);
            n_c          = nfcs_pkg::CNT_W'(5);
            is_erase_nxt = 1'b0;
          end else begin
            res_c[2] = mk(nfcs_pkg::KIND_WRITE, u1, nfcs_pkg::CMD_ERASE, 1'b0, 1'b0);
            res_c[3] = mk(nfcs_pkg::KIND_WRITE, u1, nfcs_pkg::CMD_UNLOCK1, 1'b0, 1'b0);
            res_c[4] = mk(nfcs_pkg::KIND_WRITE, u2, nfcs_pkg::CMD_UNLOCK2, 1'b0, 1'b0);
            res_c[5] = mk(nfcs_pkg::KIND_WRITE, s1_addr_r, sect_code, 1'b0, 1'b0);
            res_c[6] = mk(nfcs_pkg::KIND_READ, zero_addr, 16'd0, 1'b0, 1'b1);
            n_c             = nfcs_pkg::CNT_W'(7);
            is_erase_nxt    = 1'b1;
            sector_base_nxt = s1_addr_r;
          end
        end
      end
      nfcs_pkg::OP_STATUS: begin
        res_c[0] = mk(nfcs_pkg::KIND_READ, zero_addr, 16'd0, 1'b0, 1'b1);
        unique case (phase_r)
          PH_POLL_FIRST: begin
            old_toggle_nxt = tbit;
            phase_nxt      = PH_POLL_LOOP;
            n_c            = nfcs_pkg::CNT_W'(1);
          end
          PH_POLL_LOOP: begin
            if (tbit == old_toggle_r) begin
              phase_nxt = PH_CONF_A;
            end else begin
              old_toggle_nxt = tbit;
            end
            n_c = nfcs_pkg::CNT_W'(1);
          end
          PH_CONF_A: begin
            confirm_toggle_nxt = tbit;
            phase_nxt          = PH_CONF_B;
            n_c                = nfcs_pkg::CNT_W'(1);
          end
          PH_CONF_B: begin
            old_toggle_nxt = tbit;
            n_c            = nfcs_pkg::CNT_W'(1);
            if (tbit == confirm_toggle_r) begin
              if (!is_erase_r) begin
                phase_nxt = PH_IDLE;
                res_c[0]  = mk(nfcs_pkg::KIND_DONE, zero_addr, 16'd0, 1'b1, 1'b1);
              end else begin
                blank_index_nxt = '0;
                phase_nxt       = PH_BLANK;
                res_c[0] = mk(nfcs_pkg::KIND_READ, sector_base_r, 16'd0, 1'b0, 1'b1);
              end
            end else begin
              phase_nxt = PH_POLL_LOOP;
            end
          end
          default: begin
            res_c[0] = '0;
          end
        endcase
      end
      nfcs_pkg::OP_BLANK: begin
        if (phase_r == PH_BLANK) begin
          n_c = nfcs_pkg::CNT_W'(1);
          if (s1_data_r != nfcs_pkg::ERASED_WORD) begin
            phase_nxt = PH_IDLE;
            res_c[0]  = mk(nfcs_pkg::KIND_DONE, zero_addr, 16'd0, 1'b0, 1'b1);
          end else begin
            blank_index_nxt = idx_inc;
            if (idx_inc >= IDX_W'(SECTOR_WORDS)) begin
              phase_nxt = PH_IDLE;
              res_c[0]  = mk(nfcs_pkg::KIND_DONE, zero_addr, 16'd0, 1'b1, 1'b1);
            end else begin
              res_c[0] = mk(nfcs_pkg::KIND_READ, blank_sum[ADDR_BITS-1:0], 16'd0,
                            1'b0, 1'b1);
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    load.load  = adv;
    load.count = n_c;
    for (int i = 0; i < nfcs_pkg::MAX_RES; i++) begin
      res[i] = res_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      phase_r          <= PH_IDLE;
      is_erase_r       <= 1'b0;
      old_toggle_r     <= 1'b0;
      confirm_toggle_r <= 1'b0;
      sector_base_r    <= '0;
      blank_index_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        phase_r          <= phase_nxt;
        is_erase_r       <= is_erase_nxt;
        old_toggle_r     <= old_toggle_nxt;
        confirm_toggle_r <= confirm_toggle_nxt;
        sector_base_r    <= sector_base_nxt;
        blank_index_r    <= blank_index_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_op_r <= nfcs_pkg::OP_STATUS;
    end else if (in_fire) begin
      s1_op_r <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= in_address;
      s1_data_r <= in_data;
    end
  end

endmodule

// ===== rtl/nfcs_emit.sv =====
module nfcs_emit #(
  parameter int ADDR_BITS = 21
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  nfcs_pkg::nfcs_load_t                         load,
  input  logic [nfcs_pkg::MAX_RES-1:0][ADDR_BITS+19:0] res,
  input  logic                                         out_ready,
  output logic                                         buf_free,
  output logic                                         out_valid,
  output logic [1:0]                                   out_kind,
  output logic [ADDR_BITS-1:0]                         out_bus_address,
  output logic [15:0]                                  out_bus_data,
  output logic                                         out_success,
  output logic                                         out_last
);

  localparam int RES_W = ADDR_BITS + 20;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] addr;
    logic [15:0]          data;
    logic                 ok;
    logic                 last;
  } res_t;

  logic [RES_W-1:0]           buf_r [nfcs_pkg::MAX_RES];
  logic [nfcs_pkg::CNT_W-1:0] cnt_r;
  logic                       pop;
  res_t                       head;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign buf_free  = (cnt_r == '0) || ((cnt_r == nfcs_pkg::CNT_W'(1)) && out_ready);
  assign head      = buf_r[0];

  assign out_kind        = head.kind;
  assign out_bus_address = head.addr;
  assign out_bus_data    = head.data;
  assign out_success     = head.ok;
  assign out_last        = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load.load) begin
      cnt_r <= load.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.load) begin
      for (int i = 0; i < nfcs_pkg::MAX_RES; i++) begin
        buf_r[i] <= res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < nfcs_pkg::MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

// ===== rtl/nor_flash_command_sequencer_core.sv =====
// Channel  Dir  Beat contents
// in_ch    in   op, address, data (one request or one read-back word)
// out_ch   out  kind, bus_address, bus_data, success, last (one bus action)
// cfg      in   APB register port, chip_variant at byte address 0
//
// An accepted beat waits in the input register until the buffer is free, then its results
// load the result buffer, which sends one result per cycle while out_ch is ready.
// An erase item started in idle causes 7 results, a program item 5, others at most 1.
// A new beat is taken every cycle while items cause one result each and out_ch is ready.
// Reset is synchronous and active low; it clears the sequencer state.
// A stall on out_ch holds the buffer and then the input register.
module nor_flash_command_sequencer_core #(
  parameter int SECTOR_WORDS = 2048,
  parameter int ADDR_BITS    = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  nfcs_in_if.sink           in_ch,
  nfcs_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic                                         chip_variant_r;
  logic                                         in_fire;
  logic                                         in_ready;
  logic                                         buf_free;
  nfcs_pkg::nfcs_load_t                         load;
  logic [nfcs_pkg::MAX_RES-1:0][ADDR_BITS+19:0] res;

  assign pready      = 1'b1;
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  always_comb begin
    prdata = '0;
    if ({1'b0, paddr[2]} == nfcs_pkg::REG_CHIP_VARIANT) begin
      prdata = {31'd0, chip_variant_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_variant_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 ({1'b0, paddr[2]} == nfcs_pkg::REG_CHIP_VARIANT)) begin
      chip_variant_r <= pwdata[0];
    end
  end

  nfcs_step #(
    .SECTOR_WORDS (SECTOR_WORDS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_op        (in_ch.op),
    .in_address   (in_ch.address),
    .in_data      (in_ch.data),
    .chip_variant (chip_variant_r),
    .buf_free     (buf_free),
    .in_ready     (in_ready),
    .load         (load),
    .res          (res)
  );

  nfcs_emit #(
    .ADDR_BITS (ADDR_BITS)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .res             (res),
    .out_ready       (out_ch.ready),
    .buf_free        (buf_free),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_bus_address (out_ch.bus_address),
    .out_bus_data    (out_ch.bus_data),
    .out_success     (out_ch.success),
    .out_last        (out_ch.last)
  );

endmodule

// ===== rtl/nfcs_checker.sv =====
module nfcs_checker #(
  parameter int ADDR_BITS = 21
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_kind,
  input logic [ADDR_BITS-1:0] out_bus_address,
  input logic [15:0]          out_bus_data,
  input logic                 out_success,
  input logic                 out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == nfcs_pkg::KIND_DONE) |-> out_last && (out_bus_address == '0))
    else $error("finished beat is not the final beat of its item");

  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != nfcs_pkg::KIND_DONE) |-> !out_success)
    else $error("success flagged on a bus beat");

  a_data_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != nfcs_pkg::KIND_WRITE) |-> (out_bus_data == '0))
    else $error("nonzero data on a beat that is not a bus write");

  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == nfcs_pkg::KIND_READ) |-> out_last)
    else $error("read request is not the final beat of its item");

endmodule

bind nor_flash_command_sequencer_core nfcs_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_nfcs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_bus_address (out_ch.bus_address),
  .out_bus_data    (out_ch.bus_data),
  .out_success     (out_ch.success),
  .out_last        (out_ch.last)
);

// ===== tb/sv/nor_flash_command_sequencer_core_tb.sv =====
`timescale 1ns / 100ps

typedef struct packed {
  logic [1:0]  kind;
  logic [20:0] bus_address;
  logic [15:0] bus_data;
  logic        success;
  logic        last;
} flash_action_t;

typedef enum logic [2:0] {
  SEQ_IDLE,
  SEQ_POLL_FIRST,
  SEQ_POLL_LOOP,
  SEQ_CONFIRM_A,
  SEQ_CONFIRM_B,
  SEQ_BLANK
} seq_state_t;

class flash_sequencer_scoreboard;
  logic          variant;
  seq_state_t    seq_state;
  logic          is_erase;
  logic          old_toggle;
  logic          confirm_toggle;
  logic [20:0]   sector_base;
  int unsigned   blank_index;
  int unsigned   sector_words;
  flash_action_t bus_actions_due[$];
  int unsigned   errors;
  int unsigned   n_checked;
  int unsigned   n_program;
  int unsigned   n_erase;
  int unsigned   n_ignored;
  int unsigned   n_blank_ok;
  int unsigned   n_blank_fail;

  function new(int unsigned words);
    sector_words = words;
    variant = 1'b0;
    seq_state = SEQ_IDLE;
    is_erase = 1'b0;
    old_toggle = 1'b0;
    confirm_toggle = 1'b0;
    sector_base = '0;
    blank_index = 0;
    errors = 0;
    n_checked = 0;
    n_program = 0;
    n_erase = 0;
    n_ignored = 0;
    n_blank_ok = 0;
    n_blank_fail = 0;
  endfunction

  static function flash_action_t action(logic [1:0] kind, logic [20:0] addr,
                                        logic [15:0] data, logic ok);
    flash_action_t a;
    a.kind = kind;
    a.bus_address = addr;
    a.bus_data = data;
    a.success = ok;
    a.last = 1'b0;
    return a;
  endfunction

  function int pending();
    return bus_actions_due.size();
  endfunction

  // Works out the bus actions that one accepted beat causes.
  function int note_input(logic [1:0] op, logic [20:0] addr, logic [15:0] data);
    flash_action_t batch[$];
    flash_action_t poll;
    logic          toggle;
    logic [20:0]   unlock_a;
    logic [20:0]   unlock_b;
    toggle = data[nfcs_pkg::TOGGLE_BIT];
    unlock_a = variant ? 21'(nfcs_pkg::UNLOCK1_V1) : 21'(nfcs_pkg::UNLOCK1_V0);
    unlock_b = variant ? 21'(nfcs_pkg::UNLOCK2_V1) : 21'(nfcs_pkg::UNLOCK2_V0);
    poll = action(nfcs_pkg::KIND_READ, '0, '0, 1'b0);
    case (op)
      nfcs_pkg::OP_PROGRAM, nfcs_pkg::OP_ERASE: begin
        if (seq_state == SEQ_IDLE) begin
          batch.push_back(action(nfcs_pkg::KIND_WRITE, unlock_a, nfcs_pkg::CMD_UNLOCK1, 1'b0));
          batch.push_back(action(nfcs_pkg::KIND_WRITE, unlock_b, nfcs_pkg::CMD_UNLOCK2, 1'b0));
          if (op == nfcs_pkg::OP_PROGRAM) begin
            batch.push_back(action(nfcs_pkg::KIND_WRITE, unlock_a, nfcs_pkg::CMD_PROGRAM,
                                   1'b0));
            batch.push_back(action(nfcs_pkg::KIND_WRITE, addr, data, 1'b0));
            is_erase = 1'b0;
            n_program++;
          end else begin
            batch.push_back(action(nfcs_pkg::KIND_WRITE, unlock_a, nfcs_pkg::CMD_ERASE,
                                   1'b0));
            batch.push_back(action(nfcs_pkg::KIND_WRITE, unlock_a, nfcs_pkg::CMD_UNLOCK1,
                                   1'b0));
            batch.push_back(action(nfcs_pkg::KIND_WRITE, unlock_b, nfcs_pkg::CMD_UNLOCK2,
                                   1'b0));
            batch.push_back(action(nfcs_pkg::KIND_WRITE, addr,
                                   variant ? nfcs_pkg::CMD_SECT_V1 : nfcs_pkg::CMD_SECT_V0,
                                   1'b0));
            is_erase = 1'b1;
            sector_base = addr;
            n_erase++;
          end
          seq_state = SEQ_POLL_FIRST;
          batch.push_back(poll);
        end
      end
      nfcs_pkg::OP_STATUS: begin
        case (seq_state)
          SEQ_POLL_FIRST: begin
            old_toggle = toggle;
            seq_state = SEQ_POLL_LOOP;
            batch.push_back(poll);
          end
          SEQ_POLL_LOOP: begin
            if (toggle == old_toggle) begin
              seq_state = SEQ_CONFIRM_A;
            end else begin
              old_toggle = toggle;
            end
            batch.push_back(poll);
          end
          SEQ_CONFIRM_A: begin
            confirm_toggle = toggle;
            seq_state = SEQ_CONFIRM_B;
            batch.push_back(poll);
          end
          SEQ_CONFIRM_B: begin
            old_toggle = toggle;
            if (toggle != confirm_toggle) begin
              seq_state = SEQ_POLL_LOOP;
              batch.push_back(poll);
            end else if (!is_erase) begin
              seq_state = SEQ_IDLE;
              batch.push_back(action(nfcs_pkg::KIND_DONE, '0, '0, 1'b1));
            end else begin
              blank_index = 0;
              seq_state = SEQ_BLANK;
              batch.push_back(action(nfcs_pkg::KIND_READ, sector_base, '0, 1'b0));
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        if (seq_state == SEQ_BLANK) begin
          if (data != nfcs_pkg::ERASED_WORD) begin
            seq_state = SEQ_IDLE;
            batch.push_back(action(nfcs_pkg::KIND_DONE, '0, '0, 1'b0));
            n_blank_fail++;
          end else begin
            blank_index++;
            if (blank_index >= sector_words) begin
              seq_state = SEQ_IDLE;
              batch.push_back(action(nfcs_pkg::KIND_DONE, '0, '0, 1'b1));
              n_blank_ok++;
            end else begin
              batch.push_back(action(nfcs_pkg::KIND_READ, sector_base + 21'(blank_index),
                                     '0, 1'b0));
            end
          end
        end
      end
    endcase
    if (batch.size() == 0) begin
      n_ignored++;
    end else begin
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) bus_actions_due.push_back(batch[i]);
    end
    return batch.size();
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(flash_action_t got);
    flash_action_t want;
    if (bus_actions_due.size() == 0) begin
      $display("%0t: unexpected beat, expected none actual kind %0d address %h data %h",
               $time, got.kind, got.bus_address, got.bus_data);
      errors++;
      return;
    end
    want = bus_actions_due.pop_front();
    n_checked++;
    compare("kind", want.kind, got.kind);
    compare("bus_address", want.bus_address, got.bus_address);
    compare("bus_data", want.bus_data, got.bus_data);
    compare("success", want.success, got.success);
    compare("last", want.last, got.last);
  endfunction
endclass

module nor_flash_command_sequencer_core_tb;
  localparam int SECTOR_WORDS_TB = 2048;
  localparam int RANDOM_ITEMS = 70;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        steady;
  logic        hold_off_req;
  logic        last_toggle;
  int          last_count;
  int unsigned cycles;

  flash_sequencer_scoreboard sb;

  nfcs_in_if #(.ADDR_BITS(21)) in_ch ();
  nfcs_out_if #(.ADDR_BITS(21)) out_ch ();

  nor_flash_command_sequencer_core #(
    .SECTOR_WORDS(SECTOR_WORDS_TB),
    .ADDR_BITS(21)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("nor_flash_command_sequencer_core_tb failed");
    $finish;
  end

  initial begin
    logic hold_off_done;
    hold_off_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    flash_action_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.bus_address = out_ch.bus_address;
        got.bus_data = out_ch.bus_data;
        got.success = out_ch.success;
        got.last = out_ch.last;
        sb.check_result(got);
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [20:0] addr, input logic [15:0] data);
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.address <= addr;
    in_ch.data <= data;
    do @(posedge clk); while (!in_ch.ready);
    last_count = sb.note_input(op, addr, data);
    if (op == nfcs_pkg::OP_STATUS) last_toggle = data[nfcs_pkg::TOGGLE_BIT];
    if (!steady && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_status(input logic toggle);
    logic [15:0] word;
    word = 16'($urandom);
    word[nfcs_pkg::TOGGLE_BIT] = toggle;
    send(nfcs_pkg::OP_STATUS, 21'($urandom), word);
  endtask

  task automatic send_blank(input logic [15:0] word);
    send(nfcs_pkg::OP_BLANK, 21'($urandom), word);
  endtask

  task automatic write_chip_variant(input logic v);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(int'(nfcs_pkg::REG_CHIP_VARIANT) * 4);
    pwdata <= {31'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.variant = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.compare("chip_variant readback", {31'b0, v}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [20:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 21'h1FFFFF - 21'($urandom_range(3));
    if (r < 15) return '0;
    return 21'($urandom);
  endfunction

  function automatic logic [15:0] dirty_word();
    if ($urandom_range(1)) return 16'($urandom);
    return nfcs_pkg::ERASED_WORD ^ (16'd1 << $urandom_range(15));
  endfunction

  task automatic send_random_item();
    int r;
    r = $urandom_range(99);
    case (sb.seq_state)
      SEQ_IDLE: begin
        if (r < 85) begin
          send($urandom_range(1) ? nfcs_pkg::OP_ERASE : nfcs_pkg::OP_PROGRAM,
               pick_address(), 16'($urandom));
        end else begin
          send($urandom_range(1) ? nfcs_pkg::OP_STATUS : nfcs_pkg::OP_BLANK,
               21'($urandom), 16'($urandom));
        end
      end
      SEQ_BLANK: begin
        if (r < 85) begin
          send_blank(($urandom_range(99) < 90) ? nfcs_pkg::ERASED_WORD : dirty_word());
        end else begin
          send(2'($urandom_range(2)), pick_address(), 16'($urandom));
        end
      end
      default: begin
        if (r < 85) begin
          send_status(($urandom_range(99) < 75) ? last_toggle : ~last_toggle);
        end else begin
          send($urandom_range(1) ? nfcs_pkg::OP_BLANK : 2'($urandom_range(1)),
               pick_address(), 16'($urandom));
        end
      end
    endcase
  endtask

  initial begin
    int useful;
    int next_cfg_at;
    logic next_variant;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= nfcs_pkg::OP_PROGRAM;
    in_ch.address <= '0;
    in_ch.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 1'b0;
    hold_off_req = 1'b0;
    last_toggle = 1'b0;
    last_count = 0;
    sb = new(SECTOR_WORDS_TB);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_chip_variant(1'b0);
    send_status(1'b1);
    send_blank(nfcs_pkg::ERASED_WORD);
    send(nfcs_pkg::OP_PROGRAM, 21'h1FFFFF, 16'hFFFF);
    send(nfcs_pkg::OP_ERASE, 21'h000100, 16'h0000);
    send_status(1'b1);
    send_status(1'b0);
    send_blank(16'h0000);
    send_status(1'b0);
    send_status(1'b1);
    send_status(1'b0);
    send_status(1'b0);
    send_status(1'b0);
    send_status(1'b0);
    send_status(1'b0);
    send(nfcs_pkg::OP_ERASE, 21'h1FFFFE, 16'h1234);
    repeat (4) send_status(1'b0);
    send_blank(nfcs_pkg::ERASED_WORD);
    send(nfcs_pkg::OP_PROGRAM, 21'h000000, 16'h0000);
    repeat (3) send_blank(nfcs_pkg::ERASED_WORD);

    write_chip_variant(1'b1);
    send(nfcs_pkg::OP_ERASE, 21'h000000, 16'hFFFF);
    repeat (4) send_status(1'b1);
    send_blank(16'h0000);

    // The receiver stalls while a full erase sequence is offered, so the
    // result buffer fills and the input side has to back off.
    hold_off_req = 1'b1;
    send(nfcs_pkg::OP_ERASE, pick_address(), 16'($urandom));
    repeat (6) send_status(1'b0);

    useful = 0;
    next_cfg_at = 40;
    next_variant = 1'b0;
    while (useful < RANDOM_ITEMS) begin
      if (useful >= next_cfg_at && sb.seq_state == SEQ_IDLE) begin
        write_chip_variant(next_variant);
        next_variant = ~next_variant;
        next_cfg_at += 40;
      end
      steady = (useful >= 20 && useful < 50);
      send_random_item();
      if (last_count > 0) useful++;
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d program and %0d erase requests, %0d ignored beats, %0d results.",
             sb.n_program, sb.n_erase, sb.n_ignored, sb.n_checked);
    $display("Blank checks ended %0d times clean and %0d times on a dirty word.",
             sb.n_blank_ok, sb.n_blank_fail);
    if (sb.errors == 0) begin
      $display("nor_flash_command_sequencer_core_tb passed");
    end else begin
      $display("nor_flash_command_sequencer_core_tb failed");
    end
    $finish;
  end
endmodule
